[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of the force blend core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Implication after a fixed number of cycles.
`define ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error("delayed implication check failed");

`endif

[hw/rtl/lcb_pkg.sv]
// ----------------------------------------------------------------------------
// lcb_pkg
// Widths, register map, shared types and constants of the force blend core.
// ----------------------------------------------------------------------------
`default_nettype none

package lcb_pkg;

   localparam int LENGTH_FRACTION_BITS = 24;
   localparam int OUT_FRAC_BITS        = 24;

   localparam int LEN_W    = 31;
   localparam int VEL_W    = 32;
   localparam int FRAC_W   = 16;
   localparam int COEF_W   = 32;
   localparam int FORCE_W  = 48;
   localparam int D_W      = 33;
   localparam int FP_W     = 48;
   localparam int T_W      = 56;
   localparam int HALF_W   = 28;
   localparam int S_W      = 32;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;

   // Products of a Q16.16 coefficient drop this many bits.
   localparam int PROD_SHIFT = 16;

   localparam int DIV_STAGES   = S_W;
   localparam int HORNER_STEPS = 3;
   localparam int LATENCY      = 3 + DIV_STAGES + 2 * HORNER_STEPS + 1;

   localparam logic [LEN_W-1:0]  REST_LEN_RESET            = LEN_W'(32'h0100_0000);
   localparam logic [FRAC_W-1:0] TRANSITION_FRACTION_RESET = FRAC_W'(6554);

   typedef enum logic [2:0] {
      REG_REST_LEN              = 3'd0,
      REG_TRANSITION_FRACTION   = 3'd1,
      REG_COMPRESSION_STIFFNESS = 3'd2,
      REG_EXTENSION_STIFFNESS   = 3'd3,
      REG_DAMPING_COEFFICIENT   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [LEN_W-1:0]  rest_len;
      logic [FRAC_W-1:0] transition_fraction;
      logic [COEF_W-1:0] compression_stiffness;
      logic [COEF_W-1:0] extension_stiffness;
      logic [COEF_W-1:0] damping_coefficient;
   } cfg_type;

   // Cubic coefficients, highest order first; a0 already holds the damping.
   typedef struct packed {
      logic signed [T_W-1:0] a3;
      logic signed [T_W-1:0] a2;
      logic signed [T_W-1:0] a1;
      logic signed [T_W-1:0] a0;
   } coef_type;

endpackage

`default_nettype wire

[hw/rtl/lcb_csr.sv]
// ----------------------------------------------------------------------------
// lcb_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module lcb_csr (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        psel,
   input  wire                        penable,
   input  wire                        pwrite,
   input  wire [lcb_pkg::ADDR_W-1:0]  paddr,
   input  wire [lcb_pkg::DATA_W-1:0]  pwdata,
   output logic [lcb_pkg::DATA_W-1:0] prdata,
   output logic                       pready,
   output lcb_pkg::cfg_type           cfg
);

   lcb_pkg::cfg_type       cfg_ff, cfg_in;
   lcb_pkg::reg_index_type idx;

   assign idx    = lcb_pkg::reg_index_type'(paddr[lcb_pkg::ADDR_W-1:2]);
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (idx)
            lcb_pkg::REG_REST_LEN:
               cfg_in.rest_len = pwdata[lcb_pkg::LEN_W-1:0];
            lcb_pkg::REG_TRANSITION_FRACTION:
               cfg_in.transition_fraction = pwdata[lcb_pkg::FRAC_W-1:0];
            lcb_pkg::REG_COMPRESSION_STIFFNESS:
               cfg_in.compression_stiffness = pwdata[lcb_pkg::COEF_W-1:0];
            lcb_pkg::REG_EXTENSION_STIFFNESS:
               cfg_in.extension_stiffness = pwdata[lcb_pkg::COEF_W-1:0];
            lcb_pkg::REG_DAMPING_COEFFICIENT:
               cfg_in.damping_coefficient = pwdata[lcb_pkg::COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         lcb_pkg::REG_REST_LEN:
            prdata = lcb_pkg::DATA_W'(cfg_ff.rest_len);
         lcb_pkg::REG_TRANSITION_FRACTION:
            prdata = lcb_pkg::DATA_W'(cfg_ff.transition_fraction);
         lcb_pkg::REG_COMPRESSION_STIFFNESS:
            prdata = cfg_ff.compression_stiffness;
         lcb_pkg::REG_EXTENSION_STIFFNESS:
            prdata = cfg_ff.extension_stiffness;
         lcb_pkg::REG_DAMPING_COEFFICIENT:
            prdata = cfg_ff.damping_coefficient;
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rest_len              <= lcb_pkg::REST_LEN_RESET;
         cfg_ff.transition_fraction   <= lcb_pkg::TRANSITION_FRACTION_RESET;
         cfg_ff.compression_stiffness <= '0;
         cfg_ff.extension_stiffness   <= '0;
         cfg_ff.damping_coefficient   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/lcb_coef.sv]
// ----------------------------------------------------------------------------
// lcb_coef
// Three front stages: elongation and band width, the stiffness and damping
// products with band selection, then the cubic coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module lcb_coef (
   input  wire                               clock,
   input  wire                               reset,
   input  lcb_pkg::cfg_type                  cfg,
   input  wire                               in_valid,
   input  wire [lcb_pkg::LEN_W-1:0]          in_length,
   input  wire signed [lcb_pkg::VEL_W-1:0]   in_velocity,
   output logic                              out_valid,
   output logic [lcb_pkg::S_W-1:0]           out_n,
   output logic [lcb_pkg::LEN_W-1:0]         out_w,
   output lcb_pkg::coef_type                 out_coef
);

   localparam int LEN_W  = lcb_pkg::LEN_W;
   localparam int D_W    = lcb_pkg::D_W;
   localparam int FP_W   = lcb_pkg::FP_W;
   localparam int T_W    = lcb_pkg::T_W;
   localparam int SH     = lcb_pkg::PROD_SHIFT;
   localparam int WP_W   = LEN_W + lcb_pkg::FRAC_W;
   localparam int FCP_W  = lcb_pkg::COEF_W + D_W + 1;
   localparam int DMP_W  = lcb_pkg::COEF_W + lcb_pkg::VEL_W + 1;
   localparam int WKP_W  = lcb_pkg::COEF_W + LEN_W;
   localparam int B_W    = D_W + 1;

   // ---- stage 1 -------------------------------------------------------------
   logic                          v1_ff;
   logic signed [D_W-1:0]         d_in, d_ff;
   logic [WP_W-1:0]               wprod;
   logic [LEN_W-1:0]              w_in, w1_ff;
   logic signed [lcb_pkg::VEL_W-1:0] vel_ff;

   assign d_in  = $signed({2'b00, in_length}) - $signed({2'b00, cfg.rest_len});
   assign wprod = WP_W'(cfg.transition_fraction) * WP_W'(cfg.rest_len);
   assign w_in  = wprod[WP_W-1:lcb_pkg::FRAC_W];

   always_ff @(posedge clock) begin
      d_ff   <= d_in;
      w1_ff  <= w_in;
      vel_ff <= in_velocity;
   end

   // ---- stage 2 -------------------------------------------------------------
   logic                     v2_ff;
   logic signed [FCP_W-1:0]  fc_prod, fe_prod;
   logic signed [DMP_W-1:0]  dmp_prod;
   logic [WKP_W-1:0]         wkc_prod, wke_prod;
   logic signed [FP_W-1:0]   fc_in, fe_in, dmp_in, wkc_in, wke_in;
   logic signed [FP_W-1:0]   fc_ff, fe_ff, dmp_ff, wkc_ff, wke_ff;
   logic signed [B_W-1:0]    d2, wx, bsum;
   logic                     ext_in, comp_in, ext_ff, comp_ff;
   logic [lcb_pkg::S_W-1:0]  n_in, n2_ff;
   logic [LEN_W-1:0]         w2_ff;

   assign fc_prod  = $signed({1'b0, cfg.compression_stiffness}) * d_ff;
   assign fe_prod  = $signed({1'b0, cfg.extension_stiffness}) * d_ff;
   assign dmp_prod = $signed({1'b0, cfg.damping_coefficient}) * vel_ff;
   assign wkc_prod = WKP_W'(cfg.compression_stiffness) * WKP_W'(w1_ff);
   assign wke_prod = WKP_W'(cfg.extension_stiffness) * WKP_W'(w1_ff);

   // Dropping the low bits of a two's complement product rounds toward minus
   // infinity.
   assign fc_in  = fc_prod[FP_W+SH-1:SH];
   assign fe_in  = fe_prod[FP_W+SH-1:SH];
   assign dmp_in = dmp_prod[FP_W+SH-1:SH];
   assign wkc_in = $signed(FP_W'(wkc_prod[WKP_W-1:SH]));
   assign wke_in = $signed(FP_W'(wke_prod[WKP_W-1:SH]));

   assign d2      = $signed({d_ff, 1'b0});
   assign wx      = $signed(B_W'(w1_ff));
   assign bsum    = d2 + wx;
   assign ext_in  = d2 >= wx;
   assign comp_in = bsum <= $signed(B_W'(0));
   assign n_in    = bsum[lcb_pkg::S_W-1:0];

   always_ff @(posedge clock) begin
      fc_ff   <= fc_in;
      fe_ff   <= fe_in;
      dmp_ff  <= dmp_in;
      wkc_ff  <= wkc_in;
      wke_ff  <= wke_in;
      ext_ff  <= ext_in;
      comp_ff <= comp_in;
      n2_ff   <= n_in;
      w2_ff   <= w1_ff;
   end

   // ---- stage 3 -------------------------------------------------------------
   logic                    v3_ff;
   logic signed [T_W-1:0]   fcx, fex, wkcx, wkex, dmpx, dfe;
   lcb_pkg::coef_type       coef_in, coef_ff;
   logic [lcb_pkg::S_W-1:0] n3_ff;
   logic [LEN_W-1:0]        w3_ff;

   assign fcx  = T_W'(fc_ff);
   assign fex  = T_W'(fe_ff);
   assign wkcx = T_W'(wkc_ff);
   assign wkex = T_W'(wke_ff);
   assign dmpx = T_W'(dmp_ff);
   assign dfe  = fex - fcx;

   always_comb begin
      coef_in.a3 = wkcx + wkex - (dfe <<< 1);
      coef_in.a2 = dfe + (dfe <<< 1) - (wkcx <<< 1) - wkex;
      coef_in.a1 = wkcx;
      coef_in.a0 = (ext_ff ? fex : fcx) + dmpx;
      // Outside the band the polynomial collapses to its constant term.
      if (ext_ff || comp_ff) begin
         coef_in.a3 = '0;
         coef_in.a2 = '0;
         coef_in.a1 = '0;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
      n3_ff   <= n2_ff;
      w3_ff   <= w2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_n     = n3_ff;
   assign out_w     = w3_ff;
   assign out_coef  = coef_ff;

endmodule

`default_nettype wire

[hw/rtl/lcb_div.sv]
// ----------------------------------------------------------------------------
// lcb_div
// Pipelined restoring divider for the band position s = n * 2^31 / w,
// one quotient bit per stage, with the coefficients riding alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module lcb_div (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       in_valid,
   input  wire [lcb_pkg::S_W-1:0]    in_n,
   input  wire [lcb_pkg::LEN_W-1:0]  in_w,
   input  lcb_pkg::coef_type         in_coef,
   output logic                      out_valid,
   output logic [lcb_pkg::S_W-1:0]   out_s,
   output lcb_pkg::coef_type         out_coef
);

   localparam int N   = lcb_pkg::DIV_STAGES;
   localparam int S_W = lcb_pkg::S_W;
   localparam int L_W = lcb_pkg::LEN_W;

   logic              vld_ff   [N];
   logic [L_W-1:0]    rem_ff   [N];
   logic [L_W-1:0]    rem_in   [N];
   logic [S_W-1:0]    q_ff     [N];
   logic [S_W-1:0]    q_in     [N];
   logic [L_W-1:0]    w_ff     [N];
   lcb_pkg::coef_type coef_ff  [N];

   logic [S_W-1:0]    trial    [N];
   logic [S_W-1:0]    diff     [N];
   logic [S_W-1:0]    q_src    [N];
   logic [L_W-1:0]    w_src    [N];
   logic              vld_src  [N];
   lcb_pkg::coef_type coef_src [N];
   logic              take     [N];

   // The first stage sees n itself (below 2w inside the band); later stages
   // see the doubled remainder.
   always_comb begin
      trial[0]    = in_n;
      q_src[0]    = '0;
      w_src[0]    = in_w;
      vld_src[0]  = in_valid;
      coef_src[0] = in_coef;
      for (int k = 1; k < N; k++) begin
         trial[k]    = {rem_ff[k-1], 1'b0};
         q_src[k]    = q_ff[k-1];
         w_src[k]    = w_ff[k-1];
         vld_src[k]  = vld_ff[k-1];
         coef_src[k] = coef_ff[k-1];
      end
   end

   always_comb begin
      for (int k = 0; k < N; k++) begin
         take[k]   = trial[k] >= S_W'(w_src[k]);
         diff[k]   = trial[k] - S_W'(w_src[k]);
         rem_in[k] = take[k] ? diff[k][L_W-1:0] : trial[k][L_W-1:0];
         q_in[k]   = {q_src[k][S_W-2:0], take[k]};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         rem_ff[k]  <= rem_in[k];
         q_ff[k]    <= q_in[k];
         w_ff[k]    <= w_src[k];
         coef_ff[k] <= coef_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < N; k++) begin
            vld_ff[k] <= vld_src[k];
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_s     = q_ff[N-1];
   assign out_coef  = coef_ff[N-1];

endmodule

`default_nettype wire

[hw/rtl/lcb_horner.sv]
// ----------------------------------------------------------------------------
// lcb_horner
// Three Horner steps t = floor(t * s / 2^32) + c, each a partial product
// stage and an accumulate stage, then negation, scaling and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module lcb_horner (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                in_valid,
   input  wire [lcb_pkg::S_W-1:0]             in_s,
   input  lcb_pkg::coef_type                  in_coef,
   output logic                               out_valid,
   output logic signed [lcb_pkg::FORCE_W-1:0] out_force,
   output logic                               out_sat
);

   localparam int K     = lcb_pkg::HORNER_STEPS;
   localparam int T_W   = lcb_pkg::T_W;
   localparam int H_W   = lcb_pkg::HALF_W;
   localparam int S_W   = lcb_pkg::S_W;
   localparam int PH_W  = T_W - H_W + S_W + 1;
   localparam int PL_W  = H_W + S_W;
   localparam int SUM_W = PH_W + H_W;
   localparam int UP_SH = (lcb_pkg::OUT_FRAC_BITS >= lcb_pkg::LENGTH_FRACTION_BITS) ?
                          (lcb_pkg::OUT_FRAC_BITS - lcb_pkg::LENGTH_FRACTION_BITS) : 0;
   localparam int DN_SH = (lcb_pkg::LENGTH_FRACTION_BITS > lcb_pkg::OUT_FRAC_BITS) ?
                          (lcb_pkg::LENGTH_FRACTION_BITS - lcb_pkg::OUT_FRAC_BITS) : 0;
   localparam int EXT_W = T_W + 2 + UP_SH;
   localparam int F_W   = lcb_pkg::FORCE_W;
   localparam logic signed [EXT_W-1:0] OUT_MAX_X =
      (EXT_W'(1) <<< (F_W - 1)) - EXT_W'(1);
   localparam logic signed [EXT_W-1:0] OUT_MIN_X = -(EXT_W'(1) <<< (F_W - 1));

   // Partial product stage registers.
   logic                     a_vld_ff  [K];
   logic signed [PH_W-1:0]   ph_ff     [K];
   logic signed [PH_W-1:0]   ph_in     [K];
   logic [PL_W-1:0]          pl_ff     [K];
   logic [PL_W-1:0]          pl_in     [K];
   logic [S_W-1:0]           a_s_ff    [K];
   lcb_pkg::coef_type        a_coef_ff [K];

   // Accumulate stage registers.
   logic                     b_vld_ff  [K];
   logic signed [T_W-1:0]    t_ff      [K];
   logic signed [T_W-1:0]    t_in      [K];
   logic [S_W-1:0]           b_s_ff    [K];
   lcb_pkg::coef_type        b_coef_ff [K];

   logic signed [T_W-1:0]    t_src     [K];
   logic [S_W-1:0]           s_src     [K];
   logic                     vld_src   [K];
   lcb_pkg::coef_type        coef_src  [K];
   logic signed [SUM_W-1:0]  sum       [K];
   logic signed [T_W-1:0]    addend    [K];

   always_comb begin
      t_src[0]    = in_coef.a3;
      s_src[0]    = in_s;
      vld_src[0]  = in_valid;
      coef_src[0] = in_coef;
      for (int k = 1; k < K; k++) begin
         t_src[k]    = t_ff[k-1];
         s_src[k]    = b_s_ff[k-1];
         vld_src[k]  = b_vld_ff[k-1];
         coef_src[k] = b_coef_ff[k-1];
      end
   end

   // t * s split as (signed high half * s) * 2^H_W + (low half * s).
   always_comb begin
      for (int k = 0; k < K; k++) begin
         ph_in[k] = $signed(t_src[k][T_W-1:H_W]) * $signed({1'b0, s_src[k]});
         pl_in[k] = PL_W'(t_src[k][H_W-1:0]) * PL_W'(s_src[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < K; k++) begin
         priority if (k == 0) begin
            addend[k] = a_coef_ff[k].a2;
         end else if (k == 1) begin
            addend[k] = a_coef_ff[k].a1;
         end else begin
            addend[k] = a_coef_ff[k].a0;
         end
         sum[k]  = $signed({ph_ff[k], {H_W{1'b0}}}) + $signed(SUM_W'(pl_ff[k]));
         t_in[k] = $signed(sum[k][T_W+S_W-1:S_W]) + addend[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < K; k++) begin
         ph_ff[k]     <= ph_in[k];
         pl_ff[k]     <= pl_in[k];
         a_s_ff[k]    <= s_src[k];
         a_coef_ff[k] <= coef_src[k];
         t_ff[k]      <= t_in[k];
         b_s_ff[k]    <= a_s_ff[k];
         b_coef_ff[k] <= a_coef_ff[k];
      end
   end

   // ---- negate, rescale to Q24.24 and clip ----------------------------------
   logic signed [T_W:0]     r_neg;
   logic signed [EXT_W-1:0] rx, shifted;
   logic                    hi_clip, lo_clip;
   logic                    o_vld_ff, o_sat_ff, sat_in;
   logic signed [F_W-1:0]   o_force_ff, force_in;

   assign r_neg   = -$signed({t_ff[K-1][T_W-1], t_ff[K-1]});
   assign rx      = EXT_W'(r_neg);
   assign shifted = (lcb_pkg::OUT_FRAC_BITS >= lcb_pkg::LENGTH_FRACTION_BITS) ?
                    (rx <<< UP_SH) : (rx >>> DN_SH);
   assign hi_clip = shifted > OUT_MAX_X;
   assign lo_clip = shifted < OUT_MIN_X;
   assign sat_in  = hi_clip || lo_clip;

   always_comb begin
      priority if (hi_clip) begin
         force_in = OUT_MAX_X[F_W-1:0];
      end else if (lo_clip) begin
         force_in = OUT_MIN_X[F_W-1:0];
      end else begin
         force_in = shifted[F_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      o_force_ff <= force_in;
      o_sat_ff   <= sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < K; k++) begin
            a_vld_ff[k] <= 1'b0;
            b_vld_ff[k] <= 1'b0;
         end
         o_vld_ff <= 1'b0;
      end else begin
         for (int k = 0; k < K; k++) begin
            a_vld_ff[k] <= vld_src[k];
            b_vld_ff[k] <= a_vld_ff[k];
         end
         o_vld_ff <= b_vld_ff[K-1];
      end
   end

   assign out_valid = o_vld_ff;
   assign out_force = o_force_ff;
   assign out_sat   = o_sat_ff;

endmodule

`default_nettype wire

[hw/rtl/ligament_force_cubic_blend_core.sv]
// ----------------------------------------------------------------------------
// ligament_force_cubic_blend_core
// Spring-damper ligament force with a cubic stiffness transition band.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the 32-stage divider for the band position, one bit
// per stage, plus three front stages, six Horner stages and the output stage.
// Reset (synchronous, active high) clears all valid bits and loads the
// register defaults; items in flight are dropped.
`default_nettype none
`include "assert_macros.svh"

module ligament_force_cubic_blend_core (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire [lcb_pkg::LEN_W-1:0]            req_current_length,
   input  wire signed [lcb_pkg::VEL_W-1:0]     req_velocity,
   output logic                                rsp_strobe,
   output logic signed [lcb_pkg::FORCE_W-1:0]  rsp_force_res,
   output logic                                rsp_saturated,
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire [lcb_pkg::ADDR_W-1:0]           paddr,
   input  wire [lcb_pkg::DATA_W-1:0]           pwdata,
   output logic [lcb_pkg::DATA_W-1:0]          prdata,
   output logic                                pready
);

   lcb_pkg::cfg_type          cfg;
   logic                      accept;
   logic                      c_valid, d_valid;
   logic [lcb_pkg::S_W-1:0]   c_n, d_s;
   logic [lcb_pkg::LEN_W-1:0] c_w;
   lcb_pkg::coef_type         c_coef, d_coef;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   lcb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lcb_coef u_coef (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (accept),
      .in_length   (req_current_length),
      .in_velocity (req_velocity),
      .out_valid   (c_valid),
      .out_n       (c_n),
      .out_w       (c_w),
      .out_coef    (c_coef)
   );

   lcb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .in_n      (c_n),
      .in_w      (c_w),
      .in_coef   (c_coef),
      .out_valid (d_valid),
      .out_s     (d_s),
      .out_coef  (d_coef)
   );

   lcb_horner u_horner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_s      (d_s),
      .in_coef   (d_coef),
      .out_valid (rsp_strobe),
      .out_force (rsp_force_res),
      .out_sat   (rsp_saturated)
   );

   localparam logic signed [lcb_pkg::FORCE_W-1:0] F_MAX =
      {1'b0, {(lcb_pkg::FORCE_W-1){1'b1}}};
   localparam logic signed [lcb_pkg::FORCE_W-1:0] F_MIN =
      {1'b1, {(lcb_pkg::FORCE_W-1){1'b0}}};

   logic at_rail;
   assign at_rail = (rsp_force_res == F_MAX) || (rsp_force_res == F_MIN);

   // Every accepted beat comes out on rsp_strobe, and no strobe comes without one.
   `ASSERT_DELAY(a_latency, clock, reset, accept, lcb_pkg::LATENCY, rsp_strobe)
   `ASSERT_IMPLY(a_origin, clock, reset, rsp_strobe, $past(accept, lcb_pkg::LATENCY))
   `ASSERT_IMPLY(a_clip, clock, reset, rsp_strobe && rsp_saturated, at_rail)

endmodule

`default_nettype wire

[dv/tb_ligament_force_cubic_blend_core.sv]
// ----------------------------------------------------------------------------
// tb_ligament_force_cubic_blend_core
// Self-checking bench for the ligament force core: predicts the force and
// saturation flag of every accepted beat and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ligament_force_cubic_blend_core;

   localparam int LEN_W   = lcb_pkg::LEN_W;
   localparam int VEL_W   = lcb_pkg::VEL_W;
   localparam int FRAC_W  = lcb_pkg::FRAC_W;
   localparam int COEF_W  = lcb_pkg::COEF_W;
   localparam int FORCE_W = lcb_pkg::FORCE_W;
   localparam int ADDR_W  = lcb_pkg::ADDR_W;
   localparam int DATA_W  = lcb_pkg::DATA_W;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = lcb_pkg::LATENCY + 10;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [LEN_W-1:0]            req_current_length;
   logic signed [VEL_W-1:0]     req_velocity;
   logic                        rsp_strobe;
   logic signed [FORCE_W-1:0]   rsp_force_res;
   logic                        rsp_saturated;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [ADDR_W-1:0]           paddr;
   logic [DATA_W-1:0]           pwdata;
   logic [DATA_W-1:0]           prdata;
   logic                        pready;

   ligament_force_cubic_blend_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_current_length(req_current_length), .req_velocity(req_velocity),
      .rsp_strobe(rsp_strobe), .rsp_force_res(rsp_force_res),
      .rsp_saturated(rsp_saturated),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Local copy of the register file used by the force predictor.
   logic [LEN_W-1:0]  rest_q;
   logic [FRAC_W-1:0] frac_q;
   logic [COEF_W-1:0] kc_q;
   logic [COEF_W-1:0] ke_q;
   logic [COEF_W-1:0] kd_q;

   logic [FORCE_W-1:0] force_queue[$];
   logic               sat_queue[$];

   int errors;
   int beats_sent;
   int beats_checked;
   int sat_seen;
   int idle_pct;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void predict_force(input logic [LEN_W-1:0] len,
                                         input logic signed [VEL_W-1:0] vel,
                                         output logic [FORCE_W-1:0] force_out,
                                         output logic sat_out);
      logic signed [127:0] d, w, fc, fe, dmp, f, r, s, wkc, wke, a3, a2, t, v;
      logic signed [127:0] kc, ke, kd;
      d   = $signed({97'b0, len}) - $signed({97'b0, rest_q});
      w   = ($signed({112'b0, frac_q}) * $signed({97'b0, rest_q})) >>> 16;
      kc  = $signed({96'b0, kc_q});
      ke  = $signed({96'b0, ke_q});
      kd  = $signed({96'b0, kd_q});
      v   = vel;
      fc  = (kc * d) >>> 16;
      fe  = (ke * d) >>> 16;
      dmp = (kd * v) >>> 16;
      if (2 * d >= w) begin
         f = fe;
      end else if (2 * d + w <= 0) begin
         f = fc;
      end else begin
         // Band position in Q0.32; the Horner products floor toward minus infinity.
         s   = ((2 * d + w) <<< 31) / w;
         wkc = (kc * w) >>> 16;
         wke = (ke * w) >>> 16;
         a3  = 2 * fc - 2 * fe + wkc + wke;
         a2  = -3 * fc + 3 * fe - 2 * wkc - wke;
         t   = ((a3 * s) >>> 32) + a2;
         t   = ((t * s) >>> 32) + wkc;
         f   = ((t * s) >>> 32) + fc;
      end
      r = -(f + dmp);
      sat_out = 1'b0;
      if (r > 128'sd140737488355327) begin
         r = 128'sd140737488355327;
         sat_out = 1'b1;
      end else if (r < -128'sd140737488355328) begin
         r = -128'sd140737488355328;
         sat_out = 1'b1;
      end
      force_out = r[FORCE_W-1:0];
   endfunction

   // Result checker: every strobe beat is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (force_queue.size() == 0) begin
            $display("%0t: unexpected result beat force=%0d sat=%0b",
                     $time, rsp_force_res, rsp_saturated);
            errors++;
         end else begin
            if (rsp_force_res !== force_queue[0]) begin
               $display("%0t: force mismatch expected=%0d actual=%0d", $time,
                        $signed(force_queue[0]), rsp_force_res);
               errors++;
            end
            if (rsp_saturated !== sat_queue[0]) begin
               $display("%0t: saturated mismatch expected=%0b actual=%0b", $time,
                        sat_queue[0], rsp_saturated);
               errors++;
            end
            if (sat_queue[0]) sat_seen++;
            void'(force_queue.pop_front());
            void'(sat_queue.pop_front());
            beats_checked++;
         end
      end
   end

   // Watchdog on cycles where nothing moves on either channel.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic write_register(input lcb_pkg::reg_index_type idx,
                                 input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= ADDR_W'(4 * int'(idx));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         lcb_pkg::REG_REST_LEN:              rest_q = value[LEN_W-1:0];
         lcb_pkg::REG_TRANSITION_FRACTION:   frac_q = value[FRAC_W-1:0];
         lcb_pkg::REG_COMPRESSION_STIFFNESS: kc_q   = value;
         lcb_pkg::REG_EXTENSION_STIFFNESS:   ke_q   = value;
         lcb_pkg::REG_DAMPING_COEFFICIENT:   kd_q   = value;
         default: ;
      endcase
   endtask

   // Let the pipeline empty before the register file changes under it.
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (force_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [DATA_W-1:0] rest, input logic [DATA_W-1:0] frac,
                            input logic [DATA_W-1:0] kc, input logic [DATA_W-1:0] ke,
                            input logic [DATA_W-1:0] kd);
      wait_idle();
      write_register(lcb_pkg::REG_REST_LEN, rest);
      write_register(lcb_pkg::REG_TRANSITION_FRACTION, frac);
      write_register(lcb_pkg::REG_COMPRESSION_STIFFNESS, kc);
      write_register(lcb_pkg::REG_EXTENSION_STIFFNESS, ke);
      write_register(lcb_pkg::REG_DAMPING_COEFFICIENT, kd);
      @(posedge clock);
   endtask

   task automatic send_beat(input logic [LEN_W-1:0] len, input logic signed [VEL_W-1:0] vel);
      logic [FORCE_W-1:0] exp_force;
      logic               exp_sat;
      // Each cycle the sender stays idle with the current idle percentage.
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start              <= 1'b1;
      req_current_length <= len;
      req_velocity       <= vel;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_force(len, vel, exp_force, exp_sat);
      force_queue.push_back(exp_force);
      sat_queue.push_back(exp_sat);
      beats_sent++;
   endtask

   task automatic test_reset_defaults();
      send_beat(31'd0, 32'sd0);
      send_beat(31'h0100_0000, 32'sh7FFF_FFFF);
   endtask

   task automatic test_directed();
      logic [LEN_W-1:0] half;
      configure(32'h0100_0000, 32'd6554, 32'h0003_0000, 32'h0010_0000, 32'h0000_8000);
      half = LEN_W'((64'd6554 * 64'h0100_0000) >> 17);
      send_beat(31'd0, 32'sh8000_0000);
      send_beat(31'h7FFF_FFFF, 32'sh7FFF_FFFF);
      send_beat(31'h0100_0000, -32'sd1);
      send_beat(31'h0100_0000 + half, 32'sd0);
      send_beat(31'h0100_0000 + half - 1, 32'sd1);
      send_beat(31'h0100_0000 - half, 32'sd0);
      send_beat(31'h0100_0000 - half + 1, 32'sd0);
      send_beat(31'h0100_0000 + half / 2, 32'sd12345);
      send_beat(31'h0100_0000 - half / 3, -32'sd999);
      // A band that truncates to zero width picks the branch by the sign of the elongation.
      configure(32'd100, 32'd1, 32'h0002_0000, 32'h0005_0000, 32'd0);
      send_beat(31'd100, 32'sd0);
      send_beat(31'd99, 32'sd0);
      send_beat(31'd101, 32'sd0);
      // Register extremes that drive the force to or near both rails, from stiffness and from damping.
      configure(32'd1, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(31'h7FFF_FFFF, 32'sd0);
      send_beat(31'd0, 32'sh8000_0000);
      send_beat(31'd0, 32'sh7FFF_FFFF);
      configure(32'h7FFF_FFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      send_beat(31'd0, 32'sd0);
      send_beat(31'h7FFF_FFFF, 32'sd0);
      send_beat(31'h3FFF_FFFF, 32'sh8000_0000);
   endtask

   task automatic test_random(input int count);
      logic [LEN_W-1:0] len;
      logic [31:0]      w, off;
      configure($urandom_range(1, 32'h7FFF_FFFF), $urandom_range(1, 16'hFFFF),
                $urandom, $urandom, $urandom >> $urandom_range(31));
      w = 32'((64'(frac_q) * 64'(rest_q)) >> 16);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: len = LEN_W'($urandom);
            1: len = LEN_W'(rest_q + $urandom_range(0, w) - w / 2);
            2: len = LEN_W'(rest_q + ($urandom_range(7) - 4));
            default: begin
               off = $urandom_range(0, w / 2 + 2);
               len = LEN_W'(rest_q + ($urandom_range(1) ? off : -off));
            end
         endcase
         send_beat(len, $urandom_range(3) == 0 ? $signed($urandom) :
                   $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      end
   endtask

   task automatic test_small_coefficients(input int count);
      configure($urandom_range(1, 32'h0400_0000), $urandom_range(1, 16'hFFFF),
                $urandom_range(0, 32'h000F_FFFF), $urandom_range(0, 32'h000F_FFFF),
                $urandom_range(0, 32'h0000_FFFF));
      for (int i = 0; i < count; i++)
         send_beat(LEN_W'($urandom_range(0, 32'h0800_0000)), $signed($urandom));
   endtask

   initial begin
      errors = 0; beats_sent = 0; beats_checked = 0; sat_seen = 0; quiet_cycles = 0;
      idle_pct = 17;
      reset = 1'b1; start = 1'b0; req_current_length = '0; req_velocity = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      rest_q = lcb_pkg::REST_LEN_RESET; frac_q = lcb_pkg::TRANSITION_FRACTION_RESET;
      kc_q = '0; ke_q = '0; kd_q = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed();
      for (int p = 0; p < 3; p++) begin
         idle_pct = (p == 0) ? 17 : (p == 1) ? 78 : 0;
         test_random(70);
         test_small_coefficients(50);
         test_random(45);
      end

      wait_idle();
      $display("Sent %0d beats, checked %0d results, %0d of them saturated.",
               beats_sent, beats_checked, sat_seen);
      $display("Covered band edges, zero-width bands and register extremes.");
      if (errors == 0 && force_queue.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, force_queue.size());
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/lcb_pkg.sv
hw/rtl/lcb_csr.sv
hw/rtl/lcb_coef.sv
hw/rtl/lcb_div.sv
hw/rtl/lcb_horner.sv
hw/rtl/ligament_force_cubic_blend_core.sv
dv/tb_ligament_force_cubic_blend_core.sv
